@@ hdl/mtg_pkg.sv @@
// shared constants, payload type and datapath functions for the mt19937 generator
// no dependencies; imported by every module of the generator
`default_nettype none

package mtg_pkg;

	localparam int unsigned POOL_WORDS   = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned IDX_W        = 10;
	localparam int unsigned WORD_W       = 32;

	localparam logic [IDX_W-1:0] POOL_END  = IDX_W'(POOL_WORDS);
	localparam logic [IDX_W-1:0] POOL_LAST = IDX_W'(POOL_WORDS - 1);
	localparam logic [IDX_W-1:0] FAR_START = IDX_W'(TWIST_OFFSET);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

	typedef struct packed {
		logic              draw;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] word;
	} item_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
		wrap_inc = (v == POOL_LAST) ? '0 : v + IDX_W'(1);
	endfunction

	function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
			input logic [WORD_W-1:0] nxt, input logic [WORD_W-1:0] far);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] r;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		r = far ^ (y >> 1);
		if (y[0]) begin
			r = r ^ MATRIX_A;
		end
		twist_word = r;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v_in);
		logic [WORD_W-1:0] v;
		v = v_in;
		v = v ^ (v >> 11);
		v = v ^ ((v << 7) & TEMPER_B);
		v = v ^ ((v << 15) & TEMPER_C);
		v = v ^ (v >> 18);
		temper = v;
	endfunction

endpackage

`default_nettype wire

@@ hdl/mtg_if.sv @@
// valid/ready channel interfaces: command items in, tempered words out
// depends on mtg_pkg for field widths
`default_nettype none

interface mtg_cmd_if;
	import mtg_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [IDX_W-1:0]  load_index;
	logic [WORD_W-1:0] load_word;

	modport source (output valid, output cmd, output load_index, output load_word,
		input ready);
	modport sink (input valid, input cmd, input load_index, input load_word,
		output ready);
endinterface

interface mtg_word_if;
	import mtg_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ hdl/mtg_front.sv @@
// front end: takes command transfers, drops out-of-range loads, hands items on
// depends on mtg_pkg and mtg_cmd_if
`default_nettype none

module mtg_front import mtg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtg_cmd_if.sink    item,
	output logic       push_valid,
	input  wire logic  push_ready,
	output item_t      push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  keep;

	// a load beyond the pool changes nothing, so it never reaches the back end
	assign keep = (item.cmd == CMD_DRAW) || (item.load_index < POOL_END);
	assign item.ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.draw <= (item.cmd == CMD_DRAW);
			item_s1.idx <= item.load_index;
			item_s1.word <= item.load_word;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mtg_queue.sv @@
// two-entry queue between front and back end
// depends on mtg_pkg for the item type
`default_nettype none

module mtg_queue import mtg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mtg_back.sv @@
// back end: state pool memory, twist sequencer, tempering and output register
// depends on mtg_pkg and mtg_word_if
`default_nettype none

module mtg_back import mtg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	input  wire item_t pop_item,
	mtg_word_if.source result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_TWIST = 2'd2;
	localparam logic [1:0] ST_DRAW  = 2'd3;

	logic [WORD_W-1:0] pool_mem [POOL_WORDS];

	logic [1:0]        state_q, state_d;
	logic [IDX_W-1:0]  rp_q, rp_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [IDX_W-1:0]  next_q, next_d;
	logic [IDX_W-1:0]  far_q, far_d;
	logic [WORD_W-1:0] cur_q, cur_d;
	logic [WORD_W-1:0] rd_a_q, rd_b_q;
	logic [WORD_W-1:0] word_q;
	logic              valid_q;

	logic              rd_a_en, rd_b_en, we, out_load;
	logic [IDX_W-1:0]  rd_a_addr, rd_b_addr, wa;
	logic [WORD_W-1:0] wd;

	assign result.valid = valid_q;
	assign result.random_word = word_q;

	always_comb begin
		state_d = state_q;
		rp_d = rp_q;
		k_d = k_q;
		next_d = next_q;
		far_d = far_q;
		cur_d = cur_q;
		rd_a_en = 1'b0;
		rd_a_addr = rp_q;
		rd_b_en = 1'b0;
		rd_b_addr = far_q;
		we = 1'b0;
		wa = pop_item.idx;
		wd = pop_item.word;
		pop_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					if (!pop_item.draw) begin
						we = 1'b1;
						rp_d = POOL_END;
					end else if (rp_q >= POOL_END) begin
						// pool spent: fetch word 0 as the first current word
						rd_a_en = 1'b1;
						rd_a_addr = '0;
						next_d = IDX_W'(1);
						far_d = FAR_START;
						k_d = '0;
						state_d = ST_PRIME;
					end else begin
						rd_a_en = 1'b1;
						rd_a_addr = rp_q;
						rp_d = rp_q + IDX_W'(1);
						state_d = ST_DRAW;
					end
				end
			end
			ST_PRIME: begin
				cur_d = rd_a_q;
				rd_a_en = 1'b1;
				rd_a_addr = next_q;
				rd_b_en = 1'b1;
				rd_b_addr = far_q;
				next_d = wrap_inc(next_q);
				far_d = wrap_inc(far_q);
				state_d = ST_TWIST;
			end
			ST_TWIST: begin
				// in-place update; the far word past the wrap is already the new one
				we = 1'b1;
				wa = k_q;
				wd = twist_word(cur_q, rd_a_q, rd_b_q);
				cur_d = rd_a_q;
				k_d = k_q + IDX_W'(1);
				rd_a_en = 1'b1;
				rd_a_addr = next_q;
				rd_b_en = 1'b1;
				rd_b_addr = far_q;
				next_d = wrap_inc(next_q);
				far_d = wrap_inc(far_q);
				if (k_q == POOL_LAST) begin
					// last word written: read word 0 for the pending draw
					rd_a_addr = '0;
					rd_b_en = 1'b0;
					rp_d = IDX_W'(1);
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (!valid_q || result.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q <= POOL_END;
			k_q <= '0;
			next_q <= '0;
			far_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q <= rp_d;
			k_q <= k_d;
			next_q <= next_d;
			far_q <= far_d;
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (out_load) begin
			word_q <= temper(rd_a_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pool_mem[wa] <= wd;
		end
		if (rd_a_en) begin
			rd_a_q <= pool_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= pool_mem[rd_b_addr];
		end
	end

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= POOL_END)
		else $error("read position beyond pool end");

	a_twist_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TWIST && k_q == POOL_LAST) |=> (state_q == ST_DRAW && rp_q == IDX_W'(1)))
		else $error("regeneration did not hand over to the pending draw");

	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME || state_q == ST_DRAW) |-> !we)
		else $error("pool write outside load or twist");

	a_prime_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME) |-> ($past(state_q) == ST_IDLE && $past(rp_q) == POOL_END))
		else $error("regeneration started with pool not spent");

endmodule

`default_nettype wire

@@ hdl/mersenne_twister_generator_core.sv @@
// Mersenne twister (mt19937) generator: a 624-word state pool loaded word by word, tempered
// 32-bit draws. A load writes the pool word directly; a draw first reads the pool, then tempers
// the word into the output register. A draw that finds the pool spent, the first draw after
// any load included, first runs the twist over the whole pool, one word per cycle through the
// two-read-port pool memory. Load all 624 words before the first draw; loads with an index of
// 624 or more are dropped. The pool memory needs no clearing after reset.
// depends on mtg_pkg, mtg_if, mtg_front, mtg_queue and mtg_back
`default_nettype none

module mersenne_twister_generator_core import mtg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtg_cmd_if.sink    item,
	mtg_word_if.source result
);

	logic  push_valid, push_ready;
	item_t push_item;
	logic  pop_valid, pop_ready;
	item_t pop_item;

	mtg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mtg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mtg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.result    (result)
	);

endmodule

`default_nettype wire
